### rtl/core/tcal_pkg.sv
// Shared types, constants and constant-divider helpers for the timestamp to calendar block.
// Depends on nothing; every other file of the block but tcal_checker imports it.
package tcal_pkg;

    localparam int TIME_W = 58;
    localparam int DAYS_W = 22;
    localparam int SOD_W  = 17;

    // Rounding offset: half a centisecond in microseconds
    localparam logic [12:0] HALF_CS_US = 13'd5000;

    // Shift from the epoch to 0000-03-01
    localparam logic [DAYS_W-1:0] DAY_SHIFT = 22'd719468;

    localparam logic [13:0] YEARS_PER_ERA = 14'd400;

    // Divisors; the power-of-two parts are taken off by shifting
    localparam logic [31:0] DIV_SEC   = 32'd15625;   // 1e6 / 64
    localparam logic [31:0] DIV_DAY   = 32'd675;     // 86400 / 128
    localparam logic [31:0] DIV_CS    = 32'd625;     // 10000 / 16
    localparam logic [31:0] DIV_ERA   = 32'd146097;
    localparam logic [31:0] DIV_4Y    = 32'd1460;
    localparam logic [31:0] DIV_100Y  = 32'd36524;
    localparam logic [31:0] DIV_400Y  = 32'd146096;
    localparam logic [31:0] DIV_YEAR  = 32'd365;
    localparam logic [31:0] DIV_HOUR  = 32'd3600;
    localparam logic [31:0] DIV_MIN   = 32'd60;
    localparam logic [31:0] DIV_MONTH = 32'd153;

    // Reciprocals floor(2^32 / d): the estimate is exact or one short
    localparam logic [31:0] RCP_SEC   = 32'((64'd1 << 32) / 64'(DIV_SEC));
    localparam logic [31:0] RCP_DAY   = 32'((64'd1 << 32) / 64'(DIV_DAY));
    localparam logic [31:0] RCP_CS    = 32'((64'd1 << 32) / 64'(DIV_CS));
    localparam logic [31:0] RCP_ERA   = 32'((64'd1 << 32) / 64'(DIV_ERA));
    localparam logic [31:0] RCP_4Y    = 32'((64'd1 << 32) / 64'(DIV_4Y));
    localparam logic [31:0] RCP_100Y  = 32'((64'd1 << 32) / 64'(DIV_100Y));
    localparam logic [31:0] RCP_400Y  = 32'((64'd1 << 32) / 64'(DIV_400Y));
    localparam logic [31:0] RCP_YEAR  = 32'((64'd1 << 32) / 64'(DIV_YEAR));
    localparam logic [31:0] RCP_HOUR  = 32'((64'd1 << 32) / 64'(DIV_HOUR));
    localparam logic [31:0] RCP_MIN   = 32'((64'd1 << 32) / 64'(DIV_MIN));
    localparam logic [31:0] RCP_MONTH = 32'((64'd1 << 32) / 64'(DIV_MONTH));

    typedef struct packed {
        logic [31:0] q;
        logic [31:0] r;
    } qr_t;

    // Day count, second of day and centisecond handed to the calendar stages
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic [6:0]        cs;
    } split_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [6:0]  centisecond;
    } cal_t;

    // Quotient estimate: high word of n * rcp
    function automatic logic [31:0] quot_est(input logic [31:0] n, input logic [31:0] rcp);
        logic [63:0] prod;
        prod = {32'd0, n} * {32'd0, rcp};
        return prod[63:32];
    endfunction

    // Correct an estimate that may be one short and return quotient and remainder
    function automatic qr_t quot_fix(input logic [31:0] n, input logic [31:0] q_est,
                                     input logic [31:0] d);
        logic [63:0] prod;
        logic [31:0] r;
        qr_t         res;
        prod = {32'd0, q_est} * {32'd0, d};
        r    = n - prod[31:0];
        if (r >= d)
        begin
            res.q = q_est + 32'd1;
            res.r = r - d;
        end
        else
        begin
            res.q = q_est;
            res.r = r;
        end
        return res;
    endfunction

    // First day of a March-based month within the year: (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/tcal_sec_div.sv
// Front stages: round to centiseconds and split microseconds into days, second of day
// and centisecond by chunked constant division. Depends on tcal_pkg.
module tcal_sec_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tcal_pkg::TIME_W-1:0] time_us,
    output logic                        out_valid,
    output tcal_pkg::split_t            split
);
    import tcal_pkg::*;

    localparam int NST = 9;

    typedef struct packed {
        logic [58:0]       x;
        logic [3:0]        q1;
        logic [13:0]       rem;
        logic [17:0]       q2;
        logic [17:0]       q3;
        logic [19:0]       rem_us;
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod;
        logic [6:0]        cs;
    } sd_t;

    sd_t          st_reg  [1:NST];
    sd_t          st_next [1:NST];
    logic [NST:1] vld_reg;

    always_comb
    begin
        sd_t         s;
        logic [31:0] e;
        logic [31:0] e2;
        logic [31:0] secs_hi;
        qr_t         f;
        qr_t         f2;

        // add half a centisecond
        s      = '0;
        s.x    = 59'(time_us) + 59'(HALF_CS_US);
        st_next[1] = s;

        // top chunk of x / 1e6
        s    = st_reg[1];
        e    = quot_est(32'(s.x[58:42]), RCP_SEC);
        s.q1 = e[3:0];
        st_next[2] = s;

        s     = st_reg[2];
        f     = quot_fix(32'(s.x[58:42]), 32'(s.q1), DIV_SEC);
        s.q1  = f.q[3:0];
        s.rem = f.r[13:0];
        st_next[3] = s;

        // middle chunk
        s    = st_reg[3];
        e    = quot_est({s.rem, s.x[41:24]}, RCP_SEC);
        s.q2 = e[17:0];
        st_next[4] = s;

        s     = st_reg[4];
        f     = quot_fix({s.rem, s.x[41:24]}, 32'(s.q2), DIV_SEC);
        s.q2  = f.q[17:0];
        s.rem = f.r[13:0];
        st_next[5] = s;

        // low chunk
        s    = st_reg[5];
        e    = quot_est({s.rem, s.x[23:6]}, RCP_SEC);
        s.q3 = e[17:0];
        st_next[6] = s;

        s        = st_reg[6];
        f        = quot_fix({s.rem, s.x[23:6]}, 32'(s.q3), DIV_SEC);
        s.q3     = f.q[17:0];
        s.rem    = f.r[13:0];
        s.rem_us = {f.r[13:0], s.x[5:0]};
        st_next[7] = s;

        // seconds / 86400 and leftover microseconds / 10000
        s       = st_reg[7];
        secs_hi = {s.q1[2:0], s.q2, s.q3[17:7]};
        e       = quot_est(secs_hi, RCP_DAY);
        e2      = quot_est(32'(s.rem_us[19:4]), RCP_CS);
        s.days  = e[DAYS_W-1:0];
        s.cs    = e2[6:0];
        st_next[8] = s;

        s       = st_reg[8];
        secs_hi = {s.q1[2:0], s.q2, s.q3[17:7]};
        f       = quot_fix(secs_hi, 32'(s.days), DIV_DAY);
        f2      = quot_fix(32'(s.rem_us[19:4]), 32'(s.cs), DIV_CS);
        s.days  = f.q[DAYS_W-1:0];
        s.sod   = {f.r[9:0], s.q3[6:0]};
        s.cs    = f2.q[6:0];
        st_next[9] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid  = vld_reg[NST];
    assign split.days = st_reg[NST].days;
    assign split.sod  = st_reg[NST].sod;
    assign split.cs   = st_reg[NST].cs;

endmodule

### rtl/core/tcal_civil.sv
// Back stages: civil-from-days date conversion and time-of-day split.
// Depends on tcal_pkg.
module tcal_civil (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  tcal_pkg::split_t split,
    output logic             out_valid,
    output tcal_pkg::cal_t   cal
);
    import tcal_pkg::*;

    localparam int NST = 11;

    typedef struct packed {
        logic [DAYS_W-1:0] z;
        logic [4:0]        era;
        logic [17:0]       doe;
        logic [6:0]        qa;
        logic [2:0]        qb;
        logic              qc;
        logic [17:0]       num;
        logic [8:0]        yoe;
        logic [8:0]        doy;
        logic [3:0]        mp;
        logic [SOD_W-1:0]  sod;
        logic [4:0]        hour;
        logic [11:0]       rem_h;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic [6:0]        cs;
    } civ_t;

    civ_t         st_reg  [1:NST];
    civ_t         st_next [1:NST];
    logic [NST:1] vld_reg;
    cal_t         cal_reg;
    cal_t         cal_next;
    logic         cal_vld_reg;

    always_comb
    begin
        civ_t        s;
        logic [31:0] e;
        logic [31:0] ea;
        logic [31:0] eb;
        logic [31:0] ec;
        qr_t         f;
        qr_t         fa;
        qr_t         fb;
        qr_t         fc;
        logic [10:0] mpn;
        logic [17:0] yr_days;
        logic [17:0] doy_w;
        logic [1:0]  cent;
        logic [8:0]  dd;
        logic [3:0]  m;
        logic [13:0] yy;

        // shift epoch to March-based day count; start the hour estimate
        s      = '0;
        s.z    = split.days + DAY_SHIFT;
        s.sod  = split.sod;
        s.cs   = split.cs;
        e      = quot_est(32'(split.sod), RCP_HOUR);
        s.hour = e[4:0];
        st_next[1] = s;

        s       = st_reg[1];
        e       = quot_est(32'(s.z), RCP_ERA);
        s.era   = e[4:0];
        f       = quot_fix(32'(s.sod), 32'(s.hour), DIV_HOUR);
        s.hour  = f.q[4:0];
        s.rem_h = f.r[11:0];
        st_next[2] = s;

        s        = st_reg[2];
        f        = quot_fix(32'(s.z), 32'(s.era), DIV_ERA);
        s.era    = f.q[4:0];
        s.doe    = f.r[17:0];
        e        = quot_est(32'(s.rem_h), RCP_MIN);
        s.minute = e[5:0];
        st_next[3] = s;

        // leap corrections within the era
        s        = st_reg[3];
        ea       = quot_est(32'(s.doe), RCP_4Y);
        eb       = quot_est(32'(s.doe), RCP_100Y);
        ec       = quot_est(32'(s.doe), RCP_400Y);
        s.qa     = ea[6:0];
        s.qb     = eb[2:0];
        s.qc     = ec[0];
        f        = quot_fix(32'(s.rem_h), 32'(s.minute), DIV_MIN);
        s.minute = f.q[5:0];
        s.second = f.r[5:0];
        st_next[4] = s;

        s    = st_reg[4];
        fa   = quot_fix(32'(s.doe), 32'(s.qa), DIV_4Y);
        fb   = quot_fix(32'(s.doe), 32'(s.qb), DIV_100Y);
        fc   = quot_fix(32'(s.doe), 32'(s.qc), DIV_400Y);
        s.qa = fa.q[6:0];
        s.qb = fb.q[2:0];
        s.qc = fc.q[0];
        st_next[5] = s;

        s     = st_reg[5];
        s.num = s.doe - 18'(s.qa) + 18'(s.qb) - 18'(s.qc);
        st_next[6] = s;

        // year of era
        s     = st_reg[6];
        e     = quot_est(32'(s.num), RCP_YEAR);
        s.yoe = e[8:0];
        st_next[7] = s;

        s     = st_reg[7];
        f     = quot_fix(32'(s.num), 32'(s.yoe), DIV_YEAR);
        s.yoe = f.q[8:0];
        st_next[8] = s;

        // day of March-based year; yoe stays below 400, so centuries by compare
        s = st_reg[8];
        if (s.yoe >= 9'd300)
            cent = 2'd3;
        else if (s.yoe >= 9'd200)
            cent = 2'd2;
        else if (s.yoe >= 9'd100)
            cent = 2'd1;
        else
            cent = 2'd0;
        yr_days = 18'(s.yoe) * 18'(DIV_YEAR) + 18'(s.yoe[8:2]) - 18'(cent);
        doy_w   = s.doe - yr_days;
        s.doy   = doy_w[8:0];
        st_next[9] = s;

        // March-based month
        s    = st_reg[9];
        mpn  = 11'(s.doy) * 11'd5 + 11'd2;
        e    = quot_est(32'(mpn), RCP_MONTH);
        s.mp = e[3:0];
        st_next[10] = s;

        s    = st_reg[10];
        mpn  = 11'(s.doy) * 11'd5 + 11'd2;
        f    = quot_fix(32'(mpn), 32'(s.mp), DIV_MONTH);
        s.mp = f.q[3:0];
        st_next[11] = s;

        // final date; January and February belong to the next civil year
        s  = st_reg[11];
        dd = s.doy - month_start(s.mp) + 9'd1;
        m  = (s.mp < 4'd10) ? (s.mp + 4'd3) : (s.mp - 4'd9);
        yy = 14'(s.era) * YEARS_PER_ERA + 14'(s.yoe) + ((m <= 4'd2) ? 14'd1 : 14'd0);
        cal_next.year        = yy;
        cal_next.month       = m;
        cal_next.day         = dd[4:0];
        cal_next.hour        = s.hour;
        cal_next.minute      = s.minute;
        cal_next.second      = s.second;
        cal_next.centisecond = s.cs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            cal_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NST-1:1], in_valid};
            cal_vld_reg <= vld_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= NST; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            cal_reg <= cal_next;
        end
    end

    assign out_valid = cal_vld_reg;
    assign cal       = cal_reg;

endmodule

### rtl/core/tcal_out_skid.sv
// Output register with one skid entry; freezes the pipeline only once the skid is full.
// Depends on tcal_pkg.
module tcal_out_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pipe_valid,
    input  tcal_pkg::cal_t pipe_cal,
    output logic           en,
    input  logic           out_ready,
    output logic           out_valid,
    output tcal_pkg::cal_t out_cal
);
    import tcal_pkg::*;

    logic ov_reg;
    logic ov_next;
    logic sv_reg;
    logic sv_next;
    cal_t o_reg;
    cal_t o_next;
    cal_t s_reg;
    cal_t s_next;
    logic o_free;

    assign o_free = !ov_reg || out_ready;

    always_comb
    begin
        ov_next = ov_reg;
        sv_next = sv_reg;
        o_next  = o_reg;
        s_next  = s_reg;
        if (sv_reg)
        begin
            // drain the skid entry first
            if (o_free)
            begin
                ov_next = 1'b1;
                sv_next = 1'b0;
                o_next  = s_reg;
            end
        end
        else if (o_free)
        begin
            ov_next = pipe_valid;
            o_next  = pipe_cal;
        end
        else if (pipe_valid)
        begin
            sv_next = 1'b1;
            s_next  = pipe_cal;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
        s_reg <= s_next;
    end

    assign en        = !sv_reg;
    assign out_valid = ov_reg;
    assign out_cal   = o_reg;

endmodule

### rtl/core/timestamp_to_calendar_time_top.sv
// Timestamp to calendar time converter, top level.
// Depends on tcal_pkg, tcal_sec_div, tcal_civil and tcal_out_skid.
//
// Usage:
//   Input channel (in_valid / in_ready / time_us): one word is a count of
//   microseconds since 1970-01-01 00:00:00. Output channel (out_valid /
//   out_ready / year ... centisecond): one word per input word, the
//   proleptic Gregorian date and time of day, rounded to the nearest
//   centisecond, no leap seconds.
//   Pipeline: 9 stages of seconds/day division, 12 stages of calendar
//   conversion, 1 output register.
//   Throughput: one word per cycle while in_ready is high. Most stages hold
//   one layer of divider estimates (multiplies by reciprocals, side by side
//   where the divisions are independent) or their corrections, so unless the
//   pipeline is frozen a new word enters each cycle while older words are in
//   flight.
//   Stall: when out_ready is low the output register holds its word and the
//   next finished word drops into a skid register; only then in_ready falls
//   and the whole pipeline freezes. in_ready comes straight from a flop.
//   Reset: rst_n clears all valid bits; in_ready is high and out_valid low
//   right after reset. No clearing pass is needed.
module timestamp_to_calendar_time_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tcal_pkg::TIME_W-1:0] time_us,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [13:0]                 year,
    output logic [3:0]                  month,
    output logic [4:0]                  day,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [6:0]                  centisecond
);
    import tcal_pkg::*;

    logic   en;
    logic   split_valid;
    split_t split;
    logic   cal_valid;
    cal_t   cal;
    cal_t   out_cal;

    // the whole pipeline moves on one enable; it stops only when the skid is full
    assign in_ready = en;

    tcal_sec_div u_sec_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .time_us   (time_us),
        .out_valid (split_valid),
        .split     (split)
    );

    tcal_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (split_valid),
        .split     (split),
        .out_valid (cal_valid),
        .cal       (cal)
    );

    tcal_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (cal_valid),
        .pipe_cal   (cal),
        .en         (en),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_cal    (out_cal)
    );

    // unpack the result word onto its field ports
    assign year        = out_cal.year;
    assign month       = out_cal.month;
    assign day         = out_cal.day;
    assign hour        = out_cal.hour;
    assign minute      = out_cal.minute;
    assign second      = out_cal.second;
    assign centisecond = out_cal.centisecond;

endmodule

### rtl/core/tcal_checker.sv
// Port-level checks for the timestamp to calendar converter, bound to its top level.
// Depends on timestamp_to_calendar_time_top only through the bind below.
module tcal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [6:0]  centisecond
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
            && $stable(centisecond))
        else $error("result word changed while stalled");

    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no result waiting");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input blocked without an output stall");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59
            && centisecond <= 7'd99)
        else $error("time or date field out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 14'd1970 && year <= 14'd11200)
        else $error("year out of range");

endmodule

bind timestamp_to_calendar_time_top tcal_checker u_tcal_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .centisecond (centisecond)
);
